// ----- rtl/fpfs_pkg.sv -----
`default_nettype none

package fpfs_pkg;

   // Number of group numbers whose sequence counters are tracked at once.
   localparam int SEQ_ENTRIES = 16;
   localparam int SEQ_IDX_W   = (SEQ_ENTRIES > 1) ? $clog2(SEQ_ENTRIES) : 1;

   localparam int GROUP_W     = 18;
   localparam int SEQ_W       = 3;
   localparam int FRAME_IDX_W = 5;
   localparam int POS_W       = 3;
   localparam int BYTE_W      = 8;
   localparam int NAME_W      = 64;
   localparam int FRAME_W     = 64;

   // Byte slots inside a frame.
   localparam logic [POS_W-1:0] POS_LENGTH     = 3'd1;
   localparam logic [POS_W-1:0] POS_FIRST_DATA = 3'd2;
   localparam logic [POS_W-1:0] POS_LAST       = 3'd7;

   localparam logic [FRAME_W-1:0] FRAME_PAD = {FRAME_W{1'b1}};

   typedef struct packed {
      logic [GROUP_W-1:0] group_number;
      logic [BYTE_W-1:0]  short_source;
      logic [NAME_W-1:0]  device_name;
      logic [FRAME_W-1:0] frame_data;
      logic               last_frame;
   } rsp_word_type;

   // Replace one byte slot of a frame.
   function automatic logic [FRAME_W-1:0] put_byte(input logic [FRAME_W-1:0] frame,
                                                   input logic [POS_W-1:0]   pos,
                                                   input logic [BYTE_W-1:0]  value);
      logic [FRAME_W-1:0] result;
      result = frame;
      for (int k = 0; k < FRAME_W / BYTE_W; k++) begin
         if (pos == POS_W'(k)) begin
            result[k*BYTE_W +: BYTE_W] = value;
         end
      end
      return result;
   endfunction

   // Byte 0: sequence number in bits 7..5, frame counter in bits 4..0.
   function automatic logic [BYTE_W-1:0] header_byte(input logic [SEQ_W-1:0]       seq,
                                                     input logic [FRAME_IDX_W-1:0] index);
      return {seq, index};
   endfunction

endpackage

`default_nettype wire

// ----- rtl/fpfs_seq_table.sv -----
`default_nettype none

module fpfs_seq_table (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        lookup_en,
   input  wire logic [fpfs_pkg::GROUP_W-1:0] lookup_group,
   output logic      [fpfs_pkg::SEQ_W-1:0]   lookup_seq
);
   import fpfs_pkg::*;

   logic [GROUP_W-1:0]   tags_ff   [SEQ_ENTRIES];
   logic [SEQ_W-1:0]     counts_ff [SEQ_ENTRIES];
   logic [SEQ_ENTRIES-1:0] valid_ff;
   logic [SEQ_IDX_W-1:0] ptr_ff;
   logic [SEQ_IDX_W-1:0] ptr_in;

   logic                 hit;
   logic [SEQ_IDX_W-1:0] hit_idx;
   logic                 free_found;
   logic [SEQ_IDX_W-1:0] free_idx;
   logic [SEQ_IDX_W-1:0] victim;
   logic [SEQ_W-1:0]     count_in;

   // Lowest matching entry and lowest free entry; scanning downward leaves the lowest.
   always_comb begin
      hit        = 1'b0;
      hit_idx    = '0;
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SEQ_ENTRIES - 1; i >= 0; i--) begin
         if (valid_ff[i] && (tags_ff[i] == lookup_group)) begin
            hit     = 1'b1;
            hit_idx = SEQ_IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SEQ_IDX_W'(i);
         end
      end
   end

   always_comb begin
      lookup_seq = hit ? counts_ff[hit_idx] : '0;
      count_in   = hit ? lookup_seq + SEQ_W'(1) : SEQ_W'(1);
      priority if (hit) begin
         victim = hit_idx;
      end else if (free_found) begin
         victim = free_idx;
      end else begin
         victim = ptr_ff;
      end
      ptr_in = ptr_ff;
      if (!hit && !free_found) begin
         ptr_in = (ptr_ff == SEQ_IDX_W'(SEQ_ENTRIES - 1)) ? '0 : ptr_ff + SEQ_IDX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         ptr_ff   <= '0;
      end else if (lookup_en) begin
         valid_ff[victim] <= 1'b1;
         ptr_ff           <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (lookup_en) begin
         tags_ff[victim]   <= lookup_group;
         counts_ff[victim] <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/fpfs_packer.sv -----
`default_nettype none

module fpfs_packer (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          accept,
   input  wire logic [fpfs_pkg::BYTE_W-1:0]   payload_byte,
   input  wire logic [fpfs_pkg::BYTE_W-1:0]   total_length,
   input  wire logic [fpfs_pkg::GROUP_W-1:0]  group_number,
   input  wire logic [fpfs_pkg::BYTE_W-1:0]   short_source,
   input  wire logic [fpfs_pkg::NAME_W-1:0]   device_name,
   input  wire logic                          last_byte,
   output logic                               lookup_en,
   input  wire logic [fpfs_pkg::SEQ_W-1:0]    lookup_seq,
   output logic                               result_valid,
   output fpfs_pkg::rsp_word_type             result
);
   import fpfs_pkg::*;

   logic [FRAME_W-1:0]     buffer_ff,  buffer_in;
   logic [POS_W-1:0]       pos_ff,     pos_in;
   logic [FRAME_IDX_W-1:0] index_ff,   index_in;
   logic [SEQ_W-1:0]       seq_ff,     seq_in;
   logic                   in_msg_ff,  in_msg_in;

   logic [FRAME_W-1:0]     start_buf;
   logic [FRAME_W-1:0]     cur_buf;
   logic [POS_W-1:0]       cur_pos;
   logic [FRAME_IDX_W-1:0] cur_index;
   logic [FRAME_W-1:0]     filled;
   logic                   emit;

   assign lookup_en = accept && !in_msg_ff;

   always_comb begin
      start_buf = put_byte(put_byte(FRAME_PAD, '0, header_byte(lookup_seq, '0)),
                           POS_LENGTH, total_length);
      if (in_msg_ff) begin
         seq_in    = seq_ff;
         cur_index = index_ff;
         cur_buf   = buffer_ff;
         cur_pos   = pos_ff;
      end else begin
         seq_in    = lookup_seq;
         cur_index = '0;
         cur_buf   = start_buf;
         cur_pos   = POS_FIRST_DATA;
      end
      filled = put_byte(cur_buf, cur_pos, payload_byte);
      emit   = (cur_pos == POS_LAST) || last_byte;

      if (emit && last_byte) begin
         in_msg_in = 1'b0;
         index_in  = '0;
         pos_in    = '0;
         buffer_in = FRAME_PAD;
      end else if (emit) begin
         in_msg_in = 1'b1;
         index_in  = cur_index + FRAME_IDX_W'(1);
         pos_in    = POS_W'(1);
         buffer_in = put_byte(FRAME_PAD, '0, header_byte(seq_in, index_in));
      end else begin
         in_msg_in = 1'b1;
         index_in  = cur_index;
         pos_in    = cur_pos + POS_W'(1);
         buffer_in = filled;
      end

      result_valid        = accept && emit;
      result.group_number = group_number;
      result.short_source = short_source;
      result.device_name  = device_name;
      result.frame_data   = filled;
      result.last_frame   = last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
         pos_ff    <= '0;
         index_ff  <= '0;
         seq_ff    <= '0;
         buffer_ff <= FRAME_PAD;
      end else if (accept) begin
         in_msg_ff <= in_msg_in;
         pos_ff    <= pos_in;
         index_ff  <= index_in;
         seq_ff    <= seq_in;
         buffer_ff <= buffer_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/fpfs_out_queue.sv -----
`default_nettype none

module fpfs_out_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire fpfs_pkg::rsp_word_type push_word,
   output logic                        full,
   output logic                        out_valid,
   input  wire logic                   out_stall,
   output fpfs_pkg::rsp_word_type      out_word
);
   import fpfs_pkg::*;

   rsp_word_type main_ff, skid_ff;
   logic         main_valid_ff, skid_valid_ff;
   logic         take;

   assign take      = main_valid_ff && !out_stall;
   assign full      = skid_valid_ff;
   assign out_valid = main_valid_ff;
   assign out_word  = main_ff;

   // Pushes only arrive while the skid slot is empty.
   always_ff @(posedge clock) begin
      if (reset) begin
         main_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (main_valid_ff && !take) begin
            skid_valid_ff <= 1'b1;
         end
         main_valid_ff <= 1'b1;
      end else if (take) begin
         main_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (take) begin
            main_ff <= skid_ff;
         end
      end else if (push) begin
         if (main_valid_ff && !take) begin
            skid_ff <= push_word;
         end else begin
            main_ff <= push_word;
         end
      end
   end

endmodule

`default_nettype wire

// ----- rtl/fast_packet_frame_splitter.sv -----
// The byte completing a frame word registers it in the queue's main slot, or its skid slot if main is held.
// Throughput: one payload byte per cycle when req_stall is low; one frame word per cycle when rsp_stall is low.
// The output register plus one skid slot let bytes keep flowing after rsp_stall rises until
// one more frame is finished; req_stall then holds the sender until the receiver takes a word.
// Reset (synchronous, active high) clears the sequence table, the message state and both
// output slots; the first byte after reset starts a new message.
`default_nettype none

module fast_packet_frame_splitter (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic [fpfs_pkg::BYTE_W-1:0]   req_payload_byte,
   input  wire logic [fpfs_pkg::BYTE_W-1:0]   req_total_length,
   input  wire logic [fpfs_pkg::GROUP_W-1:0]  req_group_number,
   input  wire logic [fpfs_pkg::BYTE_W-1:0]   req_short_source,
   input  wire logic [fpfs_pkg::NAME_W-1:0]   req_device_name,
   input  wire logic                          req_last_byte,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic      [fpfs_pkg::GROUP_W-1:0]  rsp_out_group_number,
   output logic      [fpfs_pkg::BYTE_W-1:0]   rsp_out_short_source,
   output logic      [fpfs_pkg::NAME_W-1:0]   rsp_out_device_name,
   output logic      [fpfs_pkg::FRAME_W-1:0]  rsp_frame_data,
   output logic                               rsp_last_frame
);
   import fpfs_pkg::*;

   logic         accept;
   logic         lookup_en;
   logic [SEQ_W-1:0] lookup_seq;
   logic         result_valid;
   rsp_word_type result;
   logic         queue_full;
   rsp_word_type out_word;

   // A byte is taken whenever the skid slot is free; the stall comes straight from a register.
   assign req_stall = queue_full;
   assign accept    = req_valid && !req_stall;

   // On the first byte of a message the table hands out the next sequence number for the
   // group number and advances that counter, claiming a new entry on a miss.
   fpfs_seq_table u_seq_table (
      .clock        (clock),
      .reset        (reset),
      .lookup_en    (lookup_en),
      .lookup_group (req_group_number),
      .lookup_seq   (lookup_seq)
   );

   // The packer drops each byte into the frame being built and releases the frame when its
   // last slot fills or the message ends.
   fpfs_packer u_packer (
      .clock        (clock),
      .reset        (reset),
      .accept       (accept),
      .payload_byte (req_payload_byte),
      .total_length (req_total_length),
      .group_number (req_group_number),
      .short_source (req_short_source),
      .device_name  (req_device_name),
      .last_byte    (req_last_byte),
      .lookup_en    (lookup_en),
      .lookup_seq   (lookup_seq),
      .result_valid (result_valid),
      .result       (result)
   );

   // Finished frames wait here so a stalled receiver does not hold up the byte stream until both slots are full.
   fpfs_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (result_valid),
      .push_word (result),
      .full      (queue_full),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (out_word)
   );

   assign rsp_out_group_number = out_word.group_number;
   assign rsp_out_short_source = out_word.short_source;
   assign rsp_out_device_name  = out_word.device_name;
   assign rsp_frame_data       = out_word.frame_data;
   assign rsp_last_frame       = out_word.last_frame;

endmodule

`default_nettype wire
